// ----- hdl/pbat_pkg.sv -----
package pbat_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int BUDGET_W = 5;
    localparam logic [BUDGET_W-1:0] BUDGET_RST = 5'd16;

    localparam logic [7:0] MIN_SPLINE_POINTS = 8'd2;
    localparam logic [7:0] MAX_SPLINE_POINTS = 8'd16;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_ADVANCE = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_NO_ROOM = 2'd3;

    localparam logic [1:0] MODE_NONE = 2'd0;
    localparam logic [1:0] MODE_VICTIM = 2'd1;
    localparam logic [1:0] MODE_FIND = 2'd2;
    localparam logic [1:0] MODE_AGE = 2'd3;

    typedef struct packed {
        logic [31:0] id;
        logic [7:0]  pri;
        logic [31:0] age;
        logic [31:0] life;
        logic [15:0] handle;
    } t_slot;

    typedef struct packed {
        logic       load;
        logic       scan_start;
        logic [1:0] mode;
        logic       evict;
        logic       commit;
        logic       set_st;
        logic [1:0] st_val;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       add_ok;
        logic       need_evict;
        logic       scan_done;
    } t_sts;

endpackage

// ----- hdl/pbat_ram.sv -----
module pbat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/pbat_ctrl.sv -----
module pbat_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  pbat_pkg::t_sts  i_sts,
    output pbat_pkg::t_cmd  o_cmd
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_ENF = 4'd1;
    localparam logic [3:0] S_VSCAN = 4'd2;
    localparam logic [3:0] S_EVICT = 4'd3;
    localparam logic [3:0] S_DISP = 4'd4;
    localparam logic [3:0] S_FSCAN = 4'd5;
    localparam logic [3:0] S_COMMIT = 4'd6;
    localparam logic [3:0] S_ASCAN = 4'd7;
    localparam logic [3:0] S_DONE = 4'd8;

    logic [3:0] r_state, n_state;
    logic       r_post, n_post;
    logic       r_out_vld, n_out_vld;

    always_comb begin
        n_state = r_state;
        n_post = r_post;
        n_out_vld = r_out_vld;
        o_cmd = '0;
        if (r_out_vld && i_out_ready) begin
            n_out_vld = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_post = 1'b0;
                    n_state = S_ENF;
                end
            end
            S_ENF: begin
                if (i_sts.need_evict) begin
                    o_cmd.scan_start = 1'b1;
                    n_state = S_VSCAN;
                end else if (r_post) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_DISP;
                end
            end
            S_VSCAN: begin
                o_cmd.mode = pbat_pkg::MODE_VICTIM;
                if (i_sts.scan_done) begin
                    n_state = S_EVICT;
                end
            end
            S_EVICT: begin
                o_cmd.evict = 1'b1;
                n_state = S_ENF;
            end
            S_DISP: begin
                n_post = 1'b1;
                unique case (i_sts.op)
                    pbat_pkg::OP_ADD: begin
                        if (i_sts.add_ok) begin
                            o_cmd.scan_start = 1'b1;
                            n_state = S_FSCAN;
                        end else begin
                            o_cmd.set_st = 1'b1;
                            o_cmd.st_val = pbat_pkg::ST_INVALID;
                            n_state = S_ENF;
                        end
                    end
                    pbat_pkg::OP_REMOVE: begin
                        o_cmd.scan_start = 1'b1;
                        n_state = S_FSCAN;
                    end
                    pbat_pkg::OP_ADVANCE: begin
                        o_cmd.scan_start = 1'b1;
                        o_cmd.set_st = 1'b1;
                        o_cmd.st_val = pbat_pkg::ST_OK;
                        n_state = S_ASCAN;
                    end
                    pbat_pkg::OP_UNUSED: begin
                        o_cmd.set_st = 1'b1;
                        o_cmd.st_val = pbat_pkg::ST_INVALID;
                        n_state = S_ENF;
                    end
                    default: begin
                        n_state = S_ENF;
                    end
                endcase
            end
            S_FSCAN: begin
                o_cmd.mode = pbat_pkg::MODE_FIND;
                if (i_sts.scan_done) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state = S_ENF;
            end
            S_ASCAN: begin
                o_cmd.mode = pbat_pkg::MODE_AGE;
                if (i_sts.scan_done) begin
                    n_state = S_ENF;
                end
            end
            S_DONE: begin
                if (!r_out_vld || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_vld = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_post <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_post <= n_post;
            r_out_vld <= n_out_vld;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_out_valid = r_out_vld;

    a_scan_done_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.scan_done |-> (r_state == S_VSCAN || r_state == S_FSCAN || r_state == S_ASCAN))
        else $error("scan finished outside a scan state");

    a_evict_rechecks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVICT) |=> (r_state == S_ENF))
        else $error("eviction not followed by budget recheck");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !i_out_ready) |=> r_out_vld)
        else $error("result dropped before it was taken");

endmodule

// ----- hdl/pbat_dpath.sv -----
module pbat_dpath #(
    parameter int DEPTH = pbat_pkg::DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [pbat_pkg::BUDGET_W-1:0]   i_cfg_data,
    input  logic [1:0]                      i_op,
    input  logic [31:0]                     i_source_id,
    input  logic [7:0]                      i_priority_req,
    input  logic [31:0]                     i_lifetime_ms,
    input  logic [31:0]                     i_start_age_ms,
    input  logic signed [15:0]              i_volume_radius,
    input  logic                            i_is_spline,
    input  logic [7:0]                      i_spline_points,
    input  logic [15:0]                     i_payload_handle,
    input  logic [31:0]                     i_elapsed_ms,
    input  pbat_pkg::t_cmd                  i_cmd,
    output pbat_pkg::t_sts                  o_sts,
    output logic [1:0]                      o_status,
    output logic [$clog2(DEPTH+1)-1:0]      o_live_count,
    output logic [31:0]                     o_dropped_total,
    output logic [31:0]                     o_last_dropped_id
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > pbat_pkg::BUDGET_W) ? CW : pbat_pkg::BUDGET_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);

    logic [pbat_pkg::BUDGET_W-1:0] r_budget;
    logic [DEPTH-1:0]              r_valid, n_valid;
    logic [CW-1:0]                 r_count, n_count;
    logic [31:0]                   r_total, n_total;
    logic [31:0]                   r_last, n_last;
    logic [1:0]                    r_status, n_status;

    logic [1:0]        r_op;
    logic [31:0]       r_id;
    logic [7:0]        r_pri;
    logic [31:0]       r_life;
    logic [31:0]       r_age0;
    logic signed [15:0] r_radius;
    logic              r_spl;
    logic [7:0]        r_pts;
    logic [15:0]       r_handle;
    logic [31:0]       r_elapsed;

    logic          r_active;
    logic [IW-1:0] r_idx;
    logic          r_pvld;
    logic          r_plast;
    logic [IW-1:0] r_pidx;

    logic          r_vic_vld;
    logic [IW-1:0] r_vic_idx;
    logic [7:0]    r_vic_pri;
    logic [31:0]   r_vic_id;
    logic          r_hit;
    logic [IW-1:0] r_hit_idx;
    logic          r_free_vld;
    logic [IW-1:0] r_free_idx;

    logic [1:0]    r_o_status;
    logic [CW-1:0] r_o_count;
    logic [31:0]   r_o_total;
    logic [31:0]   r_o_last;

    pbat_pkg::t_slot rd_slot;
    pbat_pkg::t_slot wr_slot;
    logic [$bits(pbat_pkg::t_slot)-1:0] ram_rdata;
    logic            ram_we;
    logic [IW-1:0]   ram_waddr;

    logic        proc_valid;
    logic [32:0] age_sum;
    logic [31:0] age_sat;
    logic        expired;
    logic        better_victim;
    logic        add_write;

    assign rd_slot = pbat_pkg::t_slot'(ram_rdata);
    assign proc_valid = r_pvld && r_valid[r_pidx];

    // saturating age update
    assign age_sum = {1'b0, rd_slot.age} + {1'b0, r_elapsed};
    assign age_sat = age_sum[32] ? 32'hFFFF_FFFF : age_sum[31:0];
    assign expired = (rd_slot.life != 32'd0) && (age_sat >= rd_slot.life);

    assign better_victim = !r_vic_vld || (rd_slot.pri < r_vic_pri) ||
                           ((rd_slot.pri == r_vic_pri) && (rd_slot.id > r_vic_id));

    assign add_write = i_cmd.commit && (r_op == pbat_pkg::OP_ADD) && (r_hit || r_free_vld);

    always_comb begin
        ram_we = 1'b0;
        ram_waddr = r_pidx;
        wr_slot = rd_slot;
        if (i_cmd.mode == pbat_pkg::MODE_AGE && proc_valid) begin
            ram_we = 1'b1;
            wr_slot.age = age_sat;
        end else if (add_write) begin
            ram_we = 1'b1;
            ram_waddr = r_hit ? r_hit_idx : r_free_idx;
            wr_slot.id = r_id;
            wr_slot.pri = r_pri;
            wr_slot.age = r_age0;
            wr_slot.life = r_life;
            wr_slot.handle = r_handle;
        end
    end

    pbat_ram #(
        .WIDTH ($bits(pbat_pkg::t_slot)),
        .DEPTH (DEPTH)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (wr_slot),
        .i_re    (r_active),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    // valid bits, count, drop counters and status
    always_comb begin
        n_valid = r_valid;
        n_count = r_count;
        n_total = r_total;
        n_last = r_last;
        n_status = r_status;
        if (i_cmd.set_st) begin
            n_status = i_cmd.st_val;
        end
        if (i_cmd.mode == pbat_pkg::MODE_AGE && proc_valid && expired) begin
            n_valid[r_pidx] = 1'b0;
            n_count = r_count - 1'b1;
        end else if (i_cmd.evict && r_vic_vld) begin
            n_valid[r_vic_idx] = 1'b0;
            n_count = r_count - 1'b1;
            n_total = r_total + 32'd1;
            n_last = r_vic_id;
        end else if (i_cmd.commit) begin
            if (r_op == pbat_pkg::OP_ADD) begin
                if (r_hit) begin
                    n_status = pbat_pkg::ST_OK;
                end else if (r_free_vld) begin
                    n_valid[r_free_idx] = 1'b1;
                    n_count = r_count + 1'b1;
                    n_status = pbat_pkg::ST_OK;
                end else begin
                    n_status = pbat_pkg::ST_NO_ROOM;
                end
            end else if (r_hit) begin
                n_valid[r_hit_idx] = 1'b0;
                n_count = r_count - 1'b1;
                n_status = pbat_pkg::ST_OK;
            end else begin
                n_status = pbat_pkg::ST_NOT_FOUND;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_budget <= pbat_pkg::BUDGET_RST;
            r_valid <= '0;
            r_count <= '0;
            r_total <= '0;
            r_last <= '0;
            r_active <= 1'b0;
            r_pvld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_budget <= i_cfg_data;
            end
            r_valid <= n_valid;
            r_count <= n_count;
            r_total <= n_total;
            r_last <= n_last;
            if (i_cmd.scan_start) begin
                r_active <= 1'b1;
            end else if (r_active && r_idx == LAST_IDX) begin
                r_active <= 1'b0;
            end
            r_pvld <= r_active;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        if (i_cmd.load) begin
            r_op <= i_op;
            r_id <= i_source_id;
            r_pri <= i_priority_req;
            r_life <= i_lifetime_ms;
            r_age0 <= i_start_age_ms;
            r_radius <= i_volume_radius;
            r_spl <= i_is_spline;
            r_pts <= i_spline_points;
            r_handle <= i_payload_handle;
            r_elapsed <= i_elapsed_ms;
        end
        if (i_cmd.scan_start) begin
            r_idx <= '0;
        end else if (r_active) begin
            r_idx <= r_idx + 1'b1;
        end
        r_pidx <= r_idx;
        r_plast <= r_active && (r_idx == LAST_IDX);
        if (i_cmd.scan_start) begin
            r_vic_vld <= 1'b0;
            r_hit <= 1'b0;
            r_free_vld <= 1'b0;
        end else if (r_pvld) begin
            if (i_cmd.mode == pbat_pkg::MODE_VICTIM && r_valid[r_pidx] && better_victim) begin
                r_vic_vld <= 1'b1;
                r_vic_idx <= r_pidx;
                r_vic_pri <= rd_slot.pri;
                r_vic_id <= rd_slot.id;
            end
            if (i_cmd.mode == pbat_pkg::MODE_FIND) begin
                if (r_valid[r_pidx] && rd_slot.id == r_id && !r_hit) begin
                    r_hit <= 1'b1;
                    r_hit_idx <= r_pidx;
                end
                if (!r_valid[r_pidx] && !r_free_vld) begin
                    r_free_vld <= 1'b1;
                    r_free_idx <= r_pidx;
                end
            end
        end
        if (i_cmd.out_load) begin
            r_o_status <= r_status;
            r_o_count <= r_count;
            r_o_total <= r_total;
            r_o_last <= r_last;
        end
    end

    assign o_sts.op = r_op;
    assign o_sts.add_ok = (r_id != 32'd0) && (r_radius > 16'sd0) &&
                          (!r_spl || ((r_pts >= pbat_pkg::MIN_SPLINE_POINTS) &&
                                      (r_pts <= pbat_pkg::MAX_SPLINE_POINTS)));
    assign o_sts.need_evict = (r_count != '0) && (CMPW'(r_count) > CMPW'(r_budget));
    assign o_sts.scan_done = r_pvld && r_plast;

    assign o_status = r_o_status;
    assign o_live_count = r_o_count;
    assign o_dropped_total = r_o_total;
    assign o_last_dropped_id = r_o_last;

    a_count_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == int'(r_count))
        else $error("live count disagrees with valid bits");

    a_evict_has_victim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.evict |-> r_vic_vld)
        else $error("eviction without a victim");

    a_evict_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.evict |=> (r_total == $past(r_total) + 32'd1) &&
                        (r_count == $past(r_count) - 1'b1))
        else $error("eviction did not update counters");

endmodule

// ----- hdl/priority_bounded_aging_table_unit.sv -----
// sequence: add and remove run a find scan, advance an age scan, a rejected add or an unused
// op no scan; each eviction runs a victim scan first
// throughput: one request at a time; the next request is taken in the cycle after the
// result is loaded, later while the previous result has not been taken
// reset: synchronous, active low; clears valid bits, live count, drop total, last dropped
// id and result valid, and sets the budget to 16; the slot memory is not cleared
module priority_bounded_aging_table_unit #(
    parameter int DEPTH = pbat_pkg::DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [pbat_pkg::BUDGET_W-1:0] i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [1:0]                    i_op,
    input  logic [31:0]                   i_source_id,
    input  logic [7:0]                    i_priority_req,
    input  logic [31:0]                   i_lifetime_ms,
    input  logic [31:0]                   i_start_age_ms,
    input  logic signed [15:0]            i_volume_radius,
    input  logic                          i_is_spline,
    input  logic [7:0]                    i_spline_points,
    input  logic [15:0]                   i_payload_handle,
    input  logic [31:0]                   i_elapsed_ms,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [1:0]                    o_status,
    output logic [$clog2(DEPTH+1)-1:0]    o_live_count,
    output logic [31:0]                   o_dropped_total,
    output logic [31:0]                   o_last_dropped_id
);

    pbat_pkg::t_cmd cmd;
    pbat_pkg::t_sts sts;

    pbat_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    pbat_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_op              (i_op),
        .i_source_id       (i_source_id),
        .i_priority_req    (i_priority_req),
        .i_lifetime_ms     (i_lifetime_ms),
        .i_start_age_ms    (i_start_age_ms),
        .i_volume_radius   (i_volume_radius),
        .i_is_spline       (i_is_spline),
        .i_spline_points   (i_spline_points),
        .i_payload_handle  (i_payload_handle),
        .i_elapsed_ms      (i_elapsed_ms),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .o_status          (o_status),
        .o_live_count      (o_live_count),
        .o_dropped_total   (o_dropped_total),
        .o_last_dropped_id (o_last_dropped_id)
    );

endmodule

// ----- tb/priority_bounded_aging_table_unit_tb.sv -----
`timescale 1ns / 100ps

module priority_bounded_aging_table_unit_tb;

    typedef struct packed {
        logic [1:0]         op;
        logic [31:0]        source_id;
        logic [7:0]         priority_req;
        logic [31:0]        lifetime_ms;
        logic [31:0]        start_age_ms;
        logic signed [15:0] volume_radius;
        logic               is_spline;
        logic [7:0]         spline_points;
        logic [15:0]        payload_handle;
        logic [31:0]        elapsed_ms;
    } t_request;

    typedef struct packed {
        logic [1:0]  status;
        logic [4:0]  live_count;
        logic [31:0] dropped_total;
        logic [31:0] last_dropped_id;
    } t_reply;

    class t_aging_table_tracker;
        pbat_pkg::t_slot slots [pbat_pkg::DEPTH_DEF];
        bit              live [pbat_pkg::DEPTH_DEF];
        int unsigned     held;
        logic [4:0]      budget;
        logic [31:0]     drops;
        logic [31:0]     last_drop;
        t_reply          expected_replies [$];
        int unsigned     mismatches;

        function new();
            foreach (live[k]) live[k] = 1'b0;
            held = 0;
            budget = pbat_pkg::BUDGET_RST;
            drops = '0;
            last_drop = '0;
            mismatches = 0;
        endfunction

        function void set_budget(logic [4:0] b);
            budget = b;
        endfunction

        function int pending();
            return expected_replies.size();
        endfunction

        // lowest priority goes first, ties go to the highest id
        function void evict_worst();
            int victim;
            victim = -1;
            for (int k = 0; k < pbat_pkg::DEPTH_DEF; k++) begin
                if (live[k] && (victim < 0 || slots[k].pri < slots[victim].pri ||
                        (slots[k].pri == slots[victim].pri && slots[k].id > slots[victim].id)))
                    victim = k;
            end
            if (victim < 0)
                return;
            live[victim] = 1'b0;
            held--;
            drops++;
            last_drop = slots[victim].id;
        endfunction

        function void trim_to_budget();
            while (held > 0 && held > budget)
                evict_worst();
        endfunction

        function int find_slot(logic [31:0] id);
            for (int k = 0; k < pbat_pkg::DEPTH_DEF; k++)
                if (live[k] && slots[k].id == id)
                    return k;
            return -1;
        endfunction

        function logic [1:0] apply_add(t_request r);
            int s;
            if (r.source_id == '0)
                return pbat_pkg::ST_INVALID;
            if (r.volume_radius[15] || r.volume_radius == '0)
                return pbat_pkg::ST_INVALID;
            if (r.is_spline && (r.spline_points < pbat_pkg::MIN_SPLINE_POINTS ||
                    r.spline_points > pbat_pkg::MAX_SPLINE_POINTS))
                return pbat_pkg::ST_INVALID;
            s = find_slot(r.source_id);
            if (s < 0) begin
                for (int k = pbat_pkg::DEPTH_DEF - 1; k >= 0; k--)
                    if (!live[k])
                        s = k;
                if (s < 0)
                    return pbat_pkg::ST_NO_ROOM;
                live[s] = 1'b1;
                held++;
            end
            slots[s] = '{id: r.source_id, pri: r.priority_req, age: r.start_age_ms,
                         life: r.lifetime_ms, handle: r.payload_handle};
            trim_to_budget();
            return pbat_pkg::ST_OK;
        endfunction

        function void note_request(t_request r);
            t_reply      e;
            int          s;
            logic [32:0] sum;
            // a lowered budget bites before the request itself
            trim_to_budget();
            case (r.op)
                pbat_pkg::OP_ADD: e.status = apply_add(r);
                pbat_pkg::OP_REMOVE: begin
                    s = find_slot(r.source_id);
                    if (s < 0) begin
                        e.status = pbat_pkg::ST_NOT_FOUND;
                    end else begin
                        live[s] = 1'b0;
                        held--;
                        e.status = pbat_pkg::ST_OK;
                    end
                end
                pbat_pkg::OP_ADVANCE: begin
                    for (int k = 0; k < pbat_pkg::DEPTH_DEF; k++) begin
                        if (live[k]) begin
                            sum = {1'b0, slots[k].age} + {1'b0, r.elapsed_ms};
                            slots[k].age = sum[32] ? '1 : sum[31:0];
                            if (slots[k].life != '0 && slots[k].age >= slots[k].life) begin
                                live[k] = 1'b0;
                                held--;
                            end
                        end
                    end
                    e.status = pbat_pkg::ST_OK;
                end
                default: e.status = pbat_pkg::ST_INVALID;
            endcase
            e.live_count = 5'(held);
            e.dropped_total = drops;
            e.last_dropped_id = last_drop;
            expected_replies.insert(expected_replies.size(), e);
        endfunction

        function void check_result(t_reply got);
            t_reply want;
            if (expected_replies.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t unexpected reply: status %0d live %0d drops %0d last id %h",
                             $time, got.status, got.live_count, got.dropped_total,
                             got.last_dropped_id);
                return;
            end
            want = expected_replies.pop_front();
            if (got.status !== want.status || got.live_count !== want.live_count ||
                    got.dropped_total !== want.dropped_total ||
                    got.last_dropped_id !== want.last_dropped_id) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t reply mismatch (exp/got): status %0d/%0d live %0d/%0d",
                             $time, want.status, got.status, want.live_count,
                             got.live_count);
                    $display("    drops %0d/%0d last id %h/%h",
                             want.dropped_total, got.dropped_total,
                             want.last_dropped_id, got.last_dropped_id);
                end
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [4:0]         i_cfg_data;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [1:0]         i_op;
    logic [31:0]        i_source_id;
    logic [7:0]         i_priority_req;
    logic [31:0]        i_lifetime_ms;
    logic [31:0]        i_start_age_ms;
    logic signed [15:0] i_volume_radius;
    logic               i_is_spline;
    logic [7:0]         i_spline_points;
    logic [15:0]        i_payload_handle;
    logic [31:0]        i_elapsed_ms;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [1:0]         o_status;
    logic [4:0]         o_live_count;
    logic [31:0]        o_dropped_total;
    logic [31:0]        o_last_dropped_id;

    int unsigned        idle_pct = 0;

    t_aging_table_tracker tracker = new();

    localparam logic [4:0] BUDGET_PLAN [10] = '{5'd31, 5'd0, 5'd16, 5'd3, 5'd1,
                                                5'd31, 5'd12, 5'd17, 5'd2, 5'd16};

    priority_bounded_aging_table_unit dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_op              (i_op),
        .i_source_id       (i_source_id),
        .i_priority_req    (i_priority_req),
        .i_lifetime_ms     (i_lifetime_ms),
        .i_start_age_ms    (i_start_age_ms),
        .i_volume_radius   (i_volume_radius),
        .i_is_spline       (i_is_spline),
        .i_spline_points   (i_spline_points),
        .i_payload_handle  (i_payload_handle),
        .i_elapsed_ms      (i_elapsed_ms),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_status          (o_status),
        .o_live_count      (o_live_count),
        .o_dropped_total   (o_dropped_total),
        .o_last_dropped_id (o_last_dropped_id)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 80)
            return $urandom_range(1, 3);
        else if (roll < 95)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic logic [31:0] pick_ms(int unsigned wide_pct);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < wide_pct / 2)
            return $urandom();
        else if (roll < wide_pct)
            return 32'hFFFF_FFFF - $urandom_range(0, 100);
        else if (roll < (100 + wide_pct) / 2)
            return '0;
        else
            return $urandom_range(1, 200);
    endfunction

    function automatic t_request add_req(logic [31:0] id, logic [7:0] pri, logic [31:0] life,
                                         logic [31:0] age, logic [15:0] radius, logic spline,
                                         logic [7:0] pts, logic [15:0] handle);
        t_request r;
        r = '0;
        r.op = pbat_pkg::OP_ADD;
        r.source_id = id;
        r.priority_req = pri;
        r.lifetime_ms = life;
        r.start_age_ms = age;
        r.volume_radius = radius;
        r.is_spline = spline;
        r.spline_points = pts;
        r.payload_handle = handle;
        return r;
    endfunction

    function automatic t_request other_req(logic [1:0] op, logic [31:0] id, logic [31:0] elapsed);
        t_request r;
        r = '0;
        r.op = op;
        r.source_id = id;
        r.elapsed_ms = elapsed;
        return r;
    endfunction

    function automatic t_request random_request();
        t_request    r;
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            r.op = pbat_pkg::OP_ADD;
        else if (roll < 75)
            r.op = pbat_pkg::OP_REMOVE;
        else if (roll < 95)
            r.op = pbat_pkg::OP_ADVANCE;
        else
            r.op = pbat_pkg::OP_UNUSED;
        // small id pool so that updates, removes and a full table all happen
        roll = $urandom_range(0, 99);
        if (roll < 80)
            r.source_id = $urandom_range(1, 20);
        else if (roll < 88)
            r.source_id = '0;
        else if (roll < 96)
            r.source_id = $urandom();
        else
            r.source_id = 32'hFFFF_FFFF - $urandom_range(0, 2);
        r.priority_req = $urandom_range(0, 1) ? 8'($urandom_range(0, 7)) : 8'($urandom());
        r.lifetime_ms = pick_ms(30);
        r.start_age_ms = pick_ms(30);
        r.elapsed_ms = pick_ms(10);
        roll = $urandom_range(0, 99);
        if (roll < 85)
            r.volume_radius = 16'($urandom_range(1, 32767));
        else if (roll < 90)
            r.volume_radius = '0;
        else if (roll < 94)
            r.volume_radius = 16'h8000;
        else
            r.volume_radius = 16'($urandom());
        r.is_spline = 1'($urandom());
        r.spline_points = ($urandom_range(0, 99) < 80) ?
                          8'($urandom_range(pbat_pkg::MIN_SPLINE_POINTS,
                                            pbat_pkg::MAX_SPLINE_POINTS)) :
                          8'($urandom());
        r.payload_handle = 16'($urandom());
        return r;
    endfunction

    task automatic send_request(t_request r);
        int gap;
        @(negedge i_clk);
        gap = ($urandom_range(0, 99) < idle_pct) ? pick_gap() : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_op <= r.op;
        i_source_id <= r.source_id;
        i_priority_req <= r.priority_req;
        i_lifetime_ms <= r.lifetime_ms;
        i_start_age_ms <= r.start_age_ms;
        i_volume_radius <= r.volume_radius;
        i_is_spline <= r.is_spline;
        i_spline_points <= r.spline_points;
        i_payload_handle <= r.payload_handle;
        i_elapsed_ms <= r.elapsed_ms;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        tracker.note_request(r);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_budget(logic [4:0] b);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= b;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        tracker.set_budget(b);
    endtask

    initial begin : result_sink
        int hold;
        hold = 0;
        forever begin
            @(negedge i_clk);
            if (hold > 0) begin
                hold--;
                i_out_ready <= 1'b0;
            end else if ($urandom_range(0, 99) < idle_pct) begin
                hold = pick_gap() - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            tracker.check_result(t_reply'({o_status, o_live_count, o_dropped_total,
                                           o_last_dropped_id}));
    end

    initial begin : stimulus
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = pbat_pkg::BUDGET_RST;
        i_in_valid = 1'b0;
        i_op = pbat_pkg::OP_ADD;
        i_source_id = '0;
        i_priority_req = '0;
        i_lifetime_ms = '0;
        i_start_age_ms = '0;
        i_volume_radius = '0;
        i_is_spline = 1'b0;
        i_spline_points = '0;
        i_payload_handle = '0;
        i_elapsed_ms = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        idle_pct = 30;
        send_request(other_req(pbat_pkg::OP_REMOVE, 32'd0, 32'd0));
        send_request(other_req(pbat_pkg::OP_ADVANCE, 32'd0, 32'hFFFF_FFFF));
        send_request(other_req(pbat_pkg::OP_UNUSED, 32'd5, 32'd9));
        send_request(add_req(32'd0, 8'd9, 32'd0, 32'd0, 16'd100, 1'b0, 8'd0, 16'h1234));
        send_request(add_req(32'd1, 8'd9, 32'd0, 32'd0, 16'd0, 1'b0, 8'd0, 16'h1234));
        send_request(add_req(32'd1, 8'd9, 32'd0, 32'd0, 16'h8000, 1'b0, 8'd0, 16'h1234));
        send_request(add_req(32'd1, 8'd9, 32'd0, 32'd0, 16'hFFFF, 1'b0, 8'd0, 16'h1234));
        send_request(add_req(32'd1, 8'd9, 32'd0, 32'd0, 16'd5, 1'b1, 8'd1, 16'h1234));
        send_request(add_req(32'd1, 8'd9, 32'd0, 32'd0, 16'd5, 1'b1, 8'd17, 16'h1234));
        send_request(add_req(32'd1, 8'd0, 32'd10, 32'd0, 16'd1, 1'b1, 8'd2, 16'h0000));
        send_request(add_req(32'hFFFF_FFFF, 8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFF0, 16'h7FFF,
                             1'b1, 8'd16, 16'hFFFF));
        send_request(add_req(32'd2, 8'd0, 32'd0, 32'd0, 16'd3, 1'b0, 8'd255, 16'hAAAA));
        send_request(add_req(32'd3, 8'd0, 32'd0, 32'hFFFF_FFFF, 16'd4, 1'b0, 8'd0, 16'h5555));
        // update in place
        send_request(add_req(32'd1, 8'd0, 32'd10, 32'd5, 16'd2, 1'b0, 8'd0, 16'h0F0F));
        // lifetime reached exactly, then saturating ages
        send_request(other_req(pbat_pkg::OP_ADVANCE, 32'd0, 32'd5));
        send_request(other_req(pbat_pkg::OP_ADVANCE, 32'd0, 32'h8000_0000));
        send_request(other_req(pbat_pkg::OP_REMOVE, 32'd2, 32'd0));
        send_request(other_req(pbat_pkg::OP_REMOVE, 32'd2, 32'd0));
        send_request(other_req(pbat_pkg::OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        drain();
        // zero budget: the held entry goes first, then the new one at once
        write_budget(5'd0);
        send_request(add_req(32'd7, 8'd200, 32'd0, 32'd0, 16'd9, 1'b0, 8'd0, 16'h0707));
        drain();

        for (int p = 0; p < 10; p++) begin
            write_budget(BUDGET_PLAN[p]);
            idle_pct = (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 25 : 60);
            repeat (143) send_request(random_request());
            drain();
        end

        repeat (400) @(posedge i_clk);
        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial begin : watchdog
        #40_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
